// ----- hw/rtl/bmau_pkg.sv -----
// Shared types and constants for the block median angle unwrap design.
package bmau_pkg;

	// Default sizes handed to the top level.
	localparam int DEF_SENSORS = 4;
	localparam int DEF_WINDOW = 10;

	// Angles are tenths of a degree.
	localparam int HALF_TURN = 1800;
	localparam int FULL_TURN = 3600;

	// Width of a stored (non-negative) angle.
	localparam int MED_W = 15;

	// Reset value of the active sensor register.
	localparam logic [2:0] ACTIVE_RESET = 3'd3;

	// Command codes.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NEG = 2'd1;
	localparam logic [1:0] ST_INACT = 2'd2;

	// Input word.
	typedef struct packed {
		logic command;
		logic [1:0] sensor;
		logic signed [15:0] angle;
	} bmau_in_t;

	// Output word.
	typedef struct packed {
		logic [1:0] sensor_out;
		logic [14:0] median_angle;
		logic signed [31:0] accumulated_change;
		logic median_updated;
		logic [1:0] status;
	} bmau_out_t;

endpackage

// ----- hw/rtl/block_median_angle_unwrap_top.sv -----
// Top level of the block median angle unwrap: sequencer, window memory and median search.
//
// Usage: input words arrive on in_valid / in_stall / in_word and each one produces
// exactly one output word on out_valid / out_stall / out_word. A word is taken at a
// rising edge where valid is high and stall is low. The active sensor count is set
// through cfg_we / cfg_wdata; the user must write it only while the block is idle,
// as the block itself does not enforce this. A word that does not complete a window
// passes from acceptance through the EXEC and FIN states into the output register,
// and a new word is taken only once the previous result has moved there. A sample that
// completes a window copies the window out of the memory one slot a cycle (set by the
// single memory read port; the newest sample comes from the input word), then checks
// one median candidate per cycle against all slots, then updates the accumulator.
// in_stall stays high for the whole time one word is being worked on.
// The output register holds a finished word; while the receiver stalls it, the next
// word may already be taken and worked on, and its result waits until the register
// is free.
// Reset clears fill counts, medians, accumulators and sets the active count to 3;
// the window memory is not cleared, since only slots written in the current window
// are ever read.
module block_median_angle_unwrap_top #(
	parameter int SENSORS = bmau_pkg::DEF_SENSORS,
	parameter int WINDOW = bmau_pkg::DEF_WINDOW
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input bmau_pkg::bmau_in_t in_word,
	output logic out_valid,
	input logic out_stall,
	output bmau_pkg::bmau_out_t out_word,
	input logic cfg_we,
	input logic [2:0] cfg_wdata
);
	import bmau_pkg::*;

	localparam int SIDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
	localparam int CNT_W = $clog2(WINDOW);
	localparam int CNT1_W = $clog2(WINDOW + 1);
	localparam int HALF = WINDOW / 2;
	localparam int MEM_D = SENSORS * WINDOW;
	localparam int AW = $clog2(MEM_D);
	localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(WINDOW - 1);
	localparam logic signed [16:0] HALF_D = 17'(HALF_TURN);
	localparam logic signed [16:0] FULL_D = 17'(FULL_TURN);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_LOAD = 6'b000100,
		S_SCAN = 6'b001000,
		S_ACCUM = 6'b010000,
		S_FIN = 6'b100000
	} state_t;

	state_t state_q;
	logic [2:0] active_q;
	bmau_in_t in_q;
	bmau_out_t res_q;
	bmau_out_t out_q;
	logic out_valid_q;

	// Per-sensor state.
	logic [CNT_W-1:0] fill_q [SENSORS];
	logic [MED_W-1:0] last_med_q [SENSORS];
	logic signed [31:0] change_q [SENSORS];

	// Window memory and its local copy for the median search.
	logic [MED_W-1:0] mem [MEM_D];
	logic [MED_W-1:0] rd_q;
	logic [MED_W-1:0] win_q [WINDOW];
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] p_q;
	logic [MED_W-1:0] med_q;

	logic [SIDX_W-1:0] s_idx;
	logic active_ok;
	logic [CNT_W-1:0] fill_cur;
	logic [MED_W-1:0] last_cur;
	logic signed [31:0] acc_cur;
	logic [AW-1:0] base_addr;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic mem_we;
	logic out_free;

	logic [MED_W-1:0] cand;
	logic [WINDOW-1:0] lt_vec;
	logic [WINDOW-1:0] gt_vec;
	logic [CNT1_W-1:0] lo_cnt;
	logic [CNT1_W-1:0] hi_cnt;
	logic cand_ok;

	logic signed [16:0] d_raw;
	logic signed [16:0] d_wrap;
	logic [32:0] sum_w;
	logic signed [31:0] sat_w;

	// Decode of the word being worked on.
	always_comb begin
		s_idx = SIDX_W'(in_q.sensor);
		active_ok = ({1'b0, in_q.sensor} < active_q) && (32'(in_q.sensor) < SENSORS);
		fill_cur = fill_q[s_idx];
		last_cur = last_med_q[s_idx];
		acc_cur = change_q[s_idx];
		base_addr = AW'(s_idx) * AW'(WINDOW);
		wr_addr = base_addr + AW'(fill_cur);
		rd_addr = base_addr + AW'(k_q);
		mem_we = (state_q == S_EXEC) && active_ok && (in_q.command == CMD_SAMPLE)
			&& !in_q.angle[15];
		out_free = !out_valid_q || !out_stall;
	end

	// Window memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= in_q.angle[MED_W-1:0];
		end
		rd_q <= mem[rd_addr];
	end

	// Shared compare row: one median candidate against every slot.
	always_comb begin
		cand = win_q[p_q];
		for (int q = 0; q < WINDOW; q++) begin
			lt_vec[q] = win_q[q] < cand;
			gt_vec[q] = win_q[q] > cand;
		end
		lo_cnt = CNT1_W'($countones(lt_vec));
		hi_cnt = CNT1_W'($countones(gt_vec));
		cand_ok = (lo_cnt <= CNT1_W'(HALF)) && (hi_cnt <= CNT1_W'(HALF));
	end

	// Wrapped change of the median and saturating accumulate.
	always_comb begin
		d_raw = $signed({2'b00, med_q}) - $signed({2'b00, last_cur});
		if (d_raw < -HALF_D) begin
			d_wrap = d_raw + FULL_D;
		end else if (d_raw > HALF_D) begin
			d_wrap = d_raw - FULL_D;
		end else begin
			d_wrap = d_raw;
		end
		sum_w = {acc_cur[31], acc_cur} + 33'(d_wrap);
		if (sum_w[32] != sum_w[31]) begin
			sat_w = sum_w[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end else begin
			sat_w = sum_w[31:0];
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	// Sequencer and per-sensor state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			p_q <= '0;
			for (int i = 0; i < SENSORS; i++) begin
				fill_q[i] <= '0;
				last_med_q[i] <= '0;
				change_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_FIN;
					if (active_ok) begin
						if (in_q.command == CMD_READ) begin
							change_q[s_idx] <= '0;
						end else if (!in_q.angle[15]) begin
							if (fill_cur == LAST_SLOT) begin
								k_q <= '0;
								state_q <= S_LOAD;
							end else begin
								fill_q[s_idx] <= fill_cur + 1'b1;
							end
						end
					end
				end
				S_LOAD: begin
					if (k_q == LAST_SLOT) begin
						p_q <= '0;
						state_q <= S_SCAN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_SCAN: begin
					if (cand_ok || p_q == LAST_SLOT) begin
						state_q <= S_ACCUM;
					end else begin
						p_q <= p_q + 1'b1;
					end
				end
				S_ACCUM: begin
					last_med_q[s_idx] <= med_q;
					change_q[s_idx] <= sat_w;
					fill_q[s_idx] <= '0;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: input word, window copy, median, result word and output word.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			in_q <= in_word;
		end
		if (state_q == S_EXEC) begin
			win_q[WINDOW-1] <= in_q.angle[MED_W-1:0];
			res_q.sensor_out <= in_q.sensor;
			res_q.median_updated <= 1'b0;
			if (!active_ok) begin
				res_q.median_angle <= '0;
				res_q.accumulated_change <= '0;
				res_q.status <= ST_INACT;
			end else begin
				res_q.median_angle <= last_cur;
				res_q.accumulated_change <= acc_cur;
				res_q.status <= (in_q.command == CMD_SAMPLE && in_q.angle[15])
					? ST_NEG : ST_OK;
			end
		end
		if (state_q == S_LOAD && k_q != '0) begin
			win_q[CNT_W'(k_q - 1'b1)] <= rd_q;
		end
		if (state_q == S_SCAN) begin
			med_q <= cand_ok ? cand : win_q[0];
		end
		if (state_q == S_ACCUM) begin
			res_q.median_angle <= med_q;
			res_q.accumulated_change <= sat_w;
			res_q.median_updated <= 1'b1;
			res_q.status <= ST_OK;
		end
		if (state_q == S_FIN && out_free) begin
			out_q <= res_q;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_word = out_q;

endmodule
